// ----- rtl/core/ifp_pkg.sv -----
// Shared types, constants and helpers for the integer field parser.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package ifp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 64;
  localparam int unsigned LeftW  = 2;
  localparam int unsigned KindW  = 3;
  localparam int unsigned WidthW = 8;
  localparam int unsigned LenW   = 3;
  localparam int unsigned DigitW = 4;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned SumW   = ValueW + 4;

  localparam logic [ValueW-1:0] MagMax  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValueW-1:0] MagMin  = 64'h8000_0000_0000_0000;

  // conversion kinds
  localparam logic [KindW-1:0] KIND_DEC  = 3'd0;
  localparam logic [KindW-1:0] KIND_AUTO = 3'd1;
  localparam logic [KindW-1:0] KIND_OCT  = 3'd2;
  localparam logic [KindW-1:0] KIND_UDEC = 3'd3;
  localparam logic [KindW-1:0] KIND_HEX  = 3'd4;
  localparam logic [KindW-1:0] KIND_PTR  = 3'd5;

  // length modes
  localparam logic [LenW-1:0] LEN_CHAR  = 3'd0;
  localparam logic [LenW-1:0] LEN_SHORT = 3'd1;
  localparam logic [LenW-1:0] LEN_INT   = 3'd2;
  localparam logic [LenW-1:0] LEN_LONG  = 3'd3;
  localparam logic [LenW-1:0] LEN_LLONG = 3'd4;

  // register indexes
  localparam logic [1:0] REG_KIND  = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_LEN   = 2'd2;

  // characters
  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_NL    = 8'h0A;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_UX    = 8'h58;
  localparam logic [CharW-1:0] CH_LX    = 8'h78;

  localparam logic [4:0] NO_DIGIT = 5'd16;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SIGNED,
    PH_ZERO,
    PH_X,
    PH_PREFIXED,
    PH_DIGITS
  } phase_e;

  typedef enum logic [1:0] {
    BASE_8,
    BASE_10,
    BASE_16
  } base_e;

  typedef enum logic {
    CMD_DIGIT,
    CMD_EMIT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [DigitW-1:0] digit;
    base_e             base;
    logic              last;      // digit that also closes the field
    logic              ok;
    logic [LeftW-1:0]  left;
    logic              negative;
  } cmd_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [WidthW-1:0] max_width;
    logic [LenW-1:0]   length;
  } cfg_t;

  function automatic logic [4:0] digit_of(input logic [CharW-1:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c inside {[8'h30:8'h39]}) begin
      d = 5'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      d = 5'(c - 8'h41 + 8'd10);
    end else if (c inside {[8'h61:8'h66]}) begin
      d = 5'(c - 8'h61 + 8'd10);
    end
    return d;
  endfunction

  function automatic logic [4:0] base_val(input base_e b);
    logic [4:0] v;
    case (b)
      BASE_8:  v = 5'd8;
      BASE_16: v = 5'd16;
      default: v = 5'd10;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ifp_char_if.sv -----
// Input stream channel of the integer field parser: one text byte per item.
// Depends on ifp_pkg for the payload width.
`default_nettype none

interface ifp_char_if;
  logic                       valid;
  logic                       ready;
  logic [ifp_pkg::CharW-1:0]  character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ifp_result_if.sv -----
// Result channel of the integer field parser: one converted field per item.
// Depends on ifp_pkg for the payload widths.
`default_nettype none

interface ifp_result_if;
  logic                        valid;
  logic                        ready;
  logic                        matched;
  logic [ifp_pkg::ValueW-1:0]  value_bits;
  logic [ifp_pkg::LeftW-1:0]   unconsumed;

  modport source (output valid, output matched, output value_bits, output unconsumed,
                  input ready);
  modport sink   (input valid, input matched, input value_bits, input unconsumed,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ifp_front.sv -----
// Front end: classifies each text byte, tracks phase, sign, width and base,
// and issues digit or emit commands. Depends on ifp_pkg.
`default_nettype none

module ifp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ifp_pkg::cfg_t cfg_i,
  input  logic [7:0]    char_i,
  input  logic          accept_i,
  output ifp_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o
);
  import ifp_pkg::*;

  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [WidthW-1:0] width_q, width_d;
  base_e             base_q, base_d;

  logic [4:0]        dig;
  logic              is_ws, is_sign, is_x, is_zero, first;
  logic [WidthW-1:0] wl_fc, take_in, take_next;
  logic              take_last, fc_zero, digit_ok;
  base_e             fc_base, base_use;
  logic              do_take, do_emit, emit_ok;
  logic [LeftW-1:0]  emit_left;

  assign dig     = digit_of(char_i);
  assign is_ws   = (char_i == CH_SPACE) || (char_i == CH_TAB) || (char_i == CH_NL);
  assign is_sign = (char_i == CH_PLUS) || (char_i == CH_MINUS);
  assign is_x    = (char_i == CH_LX) || (char_i == CH_UX);
  assign is_zero = (char_i == CH_ZERO);
  assign first   = (phase_q == PH_SKIP) || (phase_q == PH_SIGNED);
  assign wl_fc   = (phase_q == PH_SKIP) ? cfg_i.max_width : width_q;

  // base chosen by the first character of the digits
  always_comb begin
    case (cfg_i.kind)
      KIND_OCT:           fc_base = BASE_8;
      KIND_AUTO:          fc_base = is_zero ? BASE_8 : BASE_10;
      KIND_HEX, KIND_PTR: fc_base = BASE_16;
      default:            fc_base = BASE_10;
    endcase
  end

  assign fc_zero = is_zero
                 && ((cfg_i.kind == KIND_AUTO) || (cfg_i.kind == KIND_HEX)
                     || (cfg_i.kind == KIND_PTR))
                 && ((wl_fc == '0) || (wl_fc >= 8'd3));

  assign base_use = first ? fc_base : base_q;
  assign digit_ok = dig < base_val(base_use);

  // width before the digit is counted
  always_comb begin
    case (phase_q)
      PH_SKIP, PH_SIGNED: take_in = wl_fc;
      PH_ZERO:            take_in = (width_q != '0) ? width_q - 8'd1 : '0;
      PH_X:               take_in = (width_q != '0) ? width_q - 8'd2 : '0;
      default:            take_in = width_q;
    endcase
  end

  assign take_next = (take_in != '0) ? take_in - 8'd1 : '0;
  assign take_last = (take_in == 8'd1);

  // classify the byte
  always_comb begin
    phase_d   = phase_q;
    neg_d     = neg_q;
    width_d   = width_q;
    base_d    = base_q;
    do_take   = 1'b0;
    do_emit   = 1'b0;
    emit_ok   = 1'b0;
    emit_left = 2'd1;
    case (phase_q)
      PH_SKIP, PH_SIGNED: begin
        if (phase_q == PH_SKIP && is_ws) begin
          // skip white space
        end else if (phase_q == PH_SKIP && char_i == CH_NUL) begin
          do_emit = 1'b1;
        end else if (phase_q == PH_SKIP && is_sign && cfg_i.max_width != 8'd1) begin
          neg_d   = (char_i == CH_MINUS);
          width_d = (cfg_i.max_width != '0) ? cfg_i.max_width - 8'd1 : '0;
          phase_d = PH_SIGNED;
        end else if (fc_zero) begin
          phase_d = PH_ZERO;
          base_d  = fc_base;
          width_d = wl_fc;
        end else if (digit_ok) begin
          do_take = 1'b1;
        end else begin
          do_emit = 1'b1;
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          if (cfg_i.kind == KIND_AUTO) begin
            width_d = (width_q != '0) ? width_q - 8'd2 : '0;
            base_d  = BASE_16;
            phase_d = PH_PREFIXED;
          end else begin
            phase_d = PH_X;
          end
        end else if (digit_ok) begin
          do_take = 1'b1;
        end else begin
          do_emit = 1'b1;
          emit_ok = 1'b1;
        end
      end
      PH_X: begin
        if (digit_ok) begin
          do_take = 1'b1;
        end else begin
          do_emit   = 1'b1;
          emit_ok   = 1'b1;
          emit_left = 2'd2;
        end
      end
      PH_PREFIXED: begin
        if (digit_ok) begin
          do_take = 1'b1;
        end else begin
          do_emit = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (digit_ok) begin
          do_take = 1'b1;
        end else begin
          do_emit = 1'b1;
          emit_ok = 1'b1;
        end
      end
      default: begin
        phase_d = PH_SKIP;
        neg_d   = 1'b0;
        width_d = '0;
        base_d  = BASE_10;
      end
    endcase

    if (do_take) begin
      phase_d = PH_DIGITS;
      width_d = take_next;
      base_d  = base_use;
    end
    // field closed: start over
    if (do_emit || (do_take && take_last)) begin
      phase_d = PH_SKIP;
      neg_d   = 1'b0;
      width_d = '0;
      base_d  = BASE_10;
    end
  end

  always_comb begin
    cmd_valid_o    = do_take || do_emit;
    cmd_o.kind     = do_take ? CMD_DIGIT : CMD_EMIT;
    cmd_o.digit    = dig[DigitW-1:0];
    cmd_o.base     = base_use;
    cmd_o.last     = do_take && take_last;
    cmd_o.ok       = emit_ok;
    cmd_o.left     = emit_left;
    cmd_o.negative = neg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      neg_q   <= 1'b0;
      width_q <= '0;
      base_q  <= BASE_10;
    end else if (accept_i) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      width_q <= width_d;
      base_q  <= base_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ifp_queue.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on ifp_pkg for the command type.
`default_nettype none

module ifp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ifp_pkg::cmd_t data_i,
  input  logic          pop_i,
  output ifp_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import ifp_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ifp_back.sv -----
// Back end: accumulates digits with overflow detection and holds the result
// register that drives the output channel. Depends on ifp_pkg.
`default_nettype none

module ifp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ifp_pkg::cfg_t               cfg_i,
  input  ifp_pkg::cmd_t               cmd_i,
  input  logic                        cmd_valid_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        matched_o,
  output logic [ifp_pkg::ValueW-1:0]  value_o,
  output logic [ifp_pkg::LeftW-1:0]   left_o
);
  import ifp_pkg::*;

  logic [ValueW-1:0] acc_q, acc_d;
  logic              ovf_q, ovf_d;
  logic              valid_q, valid_d;

  // result register
  logic              res_ok_q, res_ovf_q, res_neg_q;
  logic [ValueW-1:0] res_acc_q;
  logic [LeftW-1:0]  res_left_q;

  logic              needs_out, out_free, load;
  logic [SumW-1:0]   prod, sum;
  logic [ValueW-1:0] acc_new;
  logic              ovf_new;
  logic [LenW-1:0]   len_eff;
  logic [ValueW-1:0] raw;

  assign needs_out = (cmd_i.kind == CMD_EMIT) || cmd_i.last;
  assign out_free  = !valid_q || out_ready_i;
  assign cmd_pop_o = cmd_valid_i && (!needs_out || out_free);
  assign load      = cmd_pop_o && needs_out;

  // acc * base + digit, overflow once the magnitude passes 2^63-1
  always_comb begin
    case (cmd_i.base)
      BASE_8:  prod = {1'b0, acc_q, 3'b000};
      BASE_16: prod = {acc_q, 4'b0000};
      default: prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
    endcase
    sum     = prod + {{(SumW-DigitW){1'b0}}, cmd_i.digit};
    ovf_new = ovf_q || (sum[SumW-1:ValueW-1] != '0);
    acc_new = ovf_new ? acc_q : sum[ValueW-1:0];
  end

  always_comb begin
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (cmd_pop_o) begin
      if (needs_out) begin
        acc_d   = '0;
        ovf_d   = 1'b0;
        valid_d = 1'b1;
      end else begin
        acc_d = acc_new;
        ovf_d = ovf_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_neg_q <= cmd_i.negative;
      if (cmd_i.kind == CMD_EMIT) begin
        res_ok_q   <= cmd_i.ok;
        res_acc_q  <= acc_q;
        res_ovf_q  <= ovf_q;
        res_left_q <= cmd_i.left;
      end else begin
        res_ok_q   <= 1'b1;
        res_acc_q  <= acc_new;
        res_ovf_q  <= ovf_new;
        res_left_q <= '0;
      end
    end
  end

  // format: zero when unmatched, saturate, negate, cut to length
  always_comb begin
    len_eff = ((cfg_i.kind == KIND_PTR) || (cfg_i.length > LEN_LLONG)) ? LEN_LLONG
                                                                        : cfg_i.length;
    if (!res_ok_q) begin
      raw = '0;
    end else if (res_ovf_q) begin
      if (len_eff >= LEN_LONG) begin
        raw = res_neg_q ? MagMin : MagMax;
      end else begin
        raw = res_neg_q ? '0 : '1;
      end
    end else begin
      raw = res_neg_q ? ('0 - res_acc_q) : res_acc_q;
    end
    case (len_eff)
      LEN_CHAR:  value_o = {{(ValueW-8){raw[7]}}, raw[7:0]};
      LEN_SHORT: value_o = {{(ValueW-16){raw[15]}}, raw[15:0]};
      LEN_INT:   value_o = {{(ValueW-32){raw[31]}}, raw[31:0]};
      default:   value_o = raw;
    endcase
  end

  assign out_valid_o = valid_q;
  assign matched_o   = res_ok_q;
  assign left_o      = res_left_q;

endmodule

`default_nettype wire

// ----- rtl/core/integer_field_parser_unit.sv -----
// Integer field parser top level: APB register file, front end, command
// queue and back end. Depends on ifp_pkg, ifp_char_if, ifp_result_if.
//
// Usage:
//   char_i carries one text byte per item (0 ends the text). res_o carries
//   one item per closed field: matched, value_bits and unconsumed.
//   Registers conversion_kind, max_width and length_mode sit at byte
//   addresses 0, 4 and 8 of the APB port; write them while no field is open.
// Timing:
//   One byte is taken every cycle while the two-entry command queue has
//   room. A byte that closes a field passes through the queue into the
//   result register, which drives res_o. The per-byte loop is the
//   accumulator stage in the back end (shift-add by base plus overflow
//   compare), one byte a cycle unless a closing byte waits for a held result.
// Reset:
//   rst_ni clears the field state, queue, accumulator and result valid flag;
//   the registers return to decimal, unlimited width and int length.
// Stall:
//   A held result keeps its value; digit commands still drain, so the front
//   end keeps taking bytes until the queue fills behind the next result.
`default_nettype none

module integer_field_parser_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ifp_char_if.sink                   char_i,
  ifp_result_if.source               res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ifp_pkg::AddrW-1:0]  paddr,
  input  logic [ifp_pkg::DataW-1:0]  pwdata,
  output logic [ifp_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import ifp_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic cfg_wr;

  cmd_t front_cmd, queue_cmd;
  logic front_valid, accept;
  logic q_full, q_empty, q_pop;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[AddrW-1:2])
        REG_KIND:  cfg_d.kind      = pwdata[KindW-1:0];
        REG_WIDTH: cfg_d.max_width = pwdata[WidthW-1:0];
        REG_LEN:   cfg_d.length    = pwdata[LenW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[AddrW-1:2])
      REG_KIND:  prdata = {{(DataW-KindW){1'b0}}, cfg_q.kind};
      REG_WIDTH: prdata = {{(DataW-WidthW){1'b0}}, cfg_q.max_width};
      REG_LEN:   prdata = {{(DataW-LenW){1'b0}}, cfg_q.length};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind      <= KIND_DEC;
      cfg_q.max_width <= '0;
      cfg_q.length    <= LEN_INT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign char_i.ready = !q_full;
  assign accept       = char_i.valid && !q_full;

  ifp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .char_i      (char_i.character),
    .accept_i    (accept),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid)
  );

  ifp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && front_valid),
    .data_i  (front_cmd),
    .pop_i   (q_pop),
    .data_o  (queue_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ifp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (q_pop),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .matched_o   (res_o.matched),
    .value_o     (res_o.value_bits),
    .left_o      (res_o.unconsumed)
  );

  // a failed field always reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.matched |-> res_o.value_bits == '0)
    else $error("unmatched field with nonzero value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.unconsumed != 2'd3)
    else $error("unconsumed count out of range");

  // char length results are sign-extended from bit 7
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && cfg_q.length == LEN_CHAR && cfg_q.kind != KIND_PTR
      |-> res_o.value_bits[ValueW-1:8] == {(ValueW-8){res_o.value_bits[7]}})
    else $error("char result not sign-extended");

  // the queue never pops while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

endmodule

`default_nettype wire
